>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/dtks_pkg.sv
// ----------------------------------------------------------------------------
// dtks_pkg
// Shared types and constants of the dequantizing top-K selector.
// ----------------------------------------------------------------------------
package dtks_pkg;

  // Default sizes
  localparam int MAX_KEPT_DEF   = 8;
  localparam int INDEX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  // Dequantization modes (code 3 behaves as raw)
  localparam logic [1:0] QM_RAW   = 2'd0;
  localparam logic [1:0] QM_SHIFT = 2'd1;
  localparam logic [1:0] QM_SCALE = 2'd2;

  // Register map (word index)
  localparam logic REG_QUANT_MODE = 1'b0;
  localparam logic REG_TOP_COUNT  = 1'b1;

  localparam logic [3:0] TOP_COUNT_RST = 4'd2;

  // Input transaction
  typedef struct packed {
    logic signed [31:0] raw_value;
    logic [4:0]         shift_amount;
    logic signed [31:0] scale_factor;
    logic               last_element;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [15:0]        class_index;
    logic signed [31:0] score_value;
    logic [2:0]         rank_position;
    logic               final_result;
  } out_item_t;

  // Classified element, front to back
  typedef struct packed {
    logic signed [31:0] score;
    logic [15:0]        index;
    logic               last;
  } q_entry_t;

endpackage

>>> rtl/core/dtks_front.sv
// ----------------------------------------------------------------------------
// dtks_front
// Numbers incoming elements and dequantizes them: pass through, shift, or
// multiply with a registered product followed by rounding and saturation.
// ----------------------------------------------------------------------------
module dtks_front #(
  parameter int INDEX_BITS = dtks_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          quant_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtks_pkg::in_item_t  in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output dtks_pkg::q_entry_t  push_data
);

  logic                  accept;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_mul_r;
  logic signed [63:0]    s1_prod_r;
  logic signed [31:0]    s1_score_r;
  logic                  s1_last_r;
  logic [15:0]           s1_idx_r;
  logic signed [63:0]    mul_prod;
  logic signed [31:0]    direct_score;
  logic signed [63:0]    rnd_sum;
  logic [16:0]           rnd_hi;
  logic signed [31:0]    scaled_score;

  assign in_ready = !s1_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  // Stage 1 arithmetic
  assign mul_prod = 64'(in_data.raw_value) * 64'(in_data.scale_factor);

  always_comb begin
    case (quant_mode)
      dtks_pkg::QM_SHIFT: direct_score = in_data.raw_value >>> in_data.shift_amount;
      default:            direct_score = in_data.raw_value;
    endcase
  end

  // Element counter, restarts after the last element
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_data.last_element ? '0 : cnt_r + 1'b1;
    end
  end

  assign s1_valid_nxt = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mul_r   <= (quant_mode == dtks_pkg::QM_SCALE);
      s1_prod_r  <= mul_prod;
      s1_score_r <= direct_score;
      s1_last_r  <= in_data.last_element;
      s1_idx_r   <= 16'(cnt_r);
    end
  end

  // Round half up to Q16.16 and saturate
  assign rnd_sum = s1_prod_r + 64'sd32768;
  assign rnd_hi  = rnd_sum[63:47];

  always_comb begin
    if (rnd_hi == '0 || rnd_hi == '1) begin
      scaled_score = rnd_sum[47:16];
    end else if (rnd_sum[63]) begin
      scaled_score = 32'sh8000_0000;
    end else begin
      scaled_score = 32'sh7fff_ffff;
    end
  end

  assign push_valid      = s1_valid_r;
  assign push_data.score = s1_mul_r ? scaled_score : s1_score_r;
  assign push_data.index = s1_idx_r;
  assign push_data.last  = s1_last_r;

endmodule

>>> rtl/core/dtks_queue.sv
// ----------------------------------------------------------------------------
// dtks_queue
// Small register FIFO decoupling the dequantizer from the top-K list.
// ----------------------------------------------------------------------------
module dtks_queue #(
  parameter int DEPTH = dtks_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  dtks_pkg::q_entry_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output dtks_pkg::q_entry_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dtks_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/dtks_back.sv
// ----------------------------------------------------------------------------
// dtks_back
// Sorted top-K list built from compare-and-shift cells, one insertion per
// cycle while not reporting, and the sequencer that reports the list after the last element.
// ----------------------------------------------------------------------------
module dtks_back #(
  parameter int MAX_KEPT = dtks_pkg::MAX_KEPT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          top_count,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  dtks_pkg::q_entry_t  pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dtks_pkg::out_item_t out_data
);

  localparam int PW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  localparam logic ST_INSERT = 1'b0;
  localparam logic ST_EMIT   = 1'b1;

  logic               st_r, st_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic signed [31:0] sc_r [MAX_KEPT];
  logic [15:0]        ix_r [MAX_KEPT];
  logic [MAX_KEPT-1:0] vl_r, vl_nxt, vl_ins;
  logic signed [31:0] sc_ins [MAX_KEPT];
  logic [15:0]        ix_ins [MAX_KEPT];
  logic [MAX_KEPT-1:0] ge, lim, nv;
  logic               ins, load, load_final;
  logic               out_valid_r, out_valid_nxt;
  dtks_pkg::out_item_t out_data_r;

  assign pop_ready  = (st_r == ST_INSERT);
  assign ins        = pop_valid && pop_ready;
  assign load       = (st_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign load_final = load && !nv[ptr_r];

  // Insertion cells: keep, take the new entry, take the one above, or drop beyond top_count
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    assign ge[i]  = vl_r[i] && (sc_r[i] >= pop_data.score);
    assign lim[i] = (i == 0) || (32'(i) < 32'(top_count));
    if (i == MAX_KEPT - 1) begin : g_last
      assign nv[i] = 1'b0;
    end else begin : g_mid
      assign nv[i] = vl_r[i + 1];
    end

    always_comb begin
      sc_ins[i] = sc_r[i];
      ix_ins[i] = ix_r[i];
      vl_ins[i] = vl_r[i];
      if (!lim[i]) begin
        vl_ins[i] = 1'b0;
      end else if (!ge[i]) begin
        if (i == 0) begin
          sc_ins[i] = pop_data.score;
          ix_ins[i] = pop_data.index;
          vl_ins[i] = 1'b1;
        end else if (ge[(i == 0) ? 0 : i - 1]) begin
          sc_ins[i] = pop_data.score;
          ix_ins[i] = pop_data.index;
          vl_ins[i] = 1'b1;
        end else begin
          sc_ins[i] = sc_r[(i == 0) ? 0 : i - 1];
          ix_ins[i] = ix_r[(i == 0) ? 0 : i - 1];
          vl_ins[i] = vl_r[(i == 0) ? 0 : i - 1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ins) begin
        sc_r[i] <= sc_ins[i];
        ix_r[i] <= ix_ins[i];
      end
    end
  end

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    ptr_nxt = ptr_r;
    vl_nxt  = vl_r;
    unique case (st_r)
      ST_INSERT: begin
        if (ins) begin
          vl_nxt = vl_ins;
          if (pop_data.last) begin
            st_nxt  = ST_EMIT;
            ptr_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (load_final) begin
          vl_nxt  = '0;
          ptr_nxt = '0;
          st_nxt  = ST_INSERT;
        end else if (load) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: st_nxt = ST_INSERT;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INSERT;
      ptr_r       <= '0;
      vl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ptr_r       <= ptr_nxt;
      vl_r        <= vl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.class_index   <= ix_r[ptr_r];
      out_data_r.score_value   <= sc_r[ptr_r];
      out_data_r.rank_position <= 3'(ptr_r);
      out_data_r.final_result  <= !nv[ptr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/dequant_topk_selector_top.sv
// ----------------------------------------------------------------------------
// dequant_topk_selector_top
// Streaming top-K selection over dequantized classifier scores.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one score element per transaction (valid/ready). Each element is
//           dequantized per quant_mode, numbered, and inserted into a sorted
//           list of the best top_count entries (1 to MAX_KEPT); ties keep the earlier entry.
//   out_* : after an element with last_element set, the kept entries leave
//           best first, one transaction each, final_result on the last one.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : register port,
//           quant_mode at 0x0, top_count at 0x4; no wait states.
// Throughput: one element per cycle while the list is not reporting, set by
//   the compare-and-shift cells; results stream at one per cycle while out_ready is high.
// Result path: with the queue empty, the last accepted element passes the
//   product register, a queue slot and the insertion in the list, and then
//   the output register loads the first result.
// A 4-entry queue sits between dequantizer and list. While results drain
//   the list takes no elements; the input still fills the queue.
// Reset (synchronous): list empty, element counter zero, quant_mode 0,
//   top_count 2. A stalled receiver holds the current result and the
//   sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dequant_topk_selector_top #(
  parameter int MAX_KEPT   = dtks_pkg::MAX_KEPT_DEF,
  parameter int INDEX_BITS = dtks_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  dtks_pkg::in_item_t  in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output dtks_pkg::out_item_t out_data,
  // Register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]         quant_mode_r;
  logic [3:0]         top_count_r;
  logic               cfg_wr;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  dtks_pkg::q_entry_t push_data, pop_data;
  logic               out_take, out_more, out_last;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_mode_r <= dtks_pkg::QM_RAW;
      top_count_r  <= dtks_pkg::TOP_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dtks_pkg::REG_QUANT_MODE: quant_mode_r <= pwdata[1:0];
        dtks_pkg::REG_TOP_COUNT:  top_count_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dtks_pkg::REG_QUANT_MODE: prdata = {30'd0, quant_mode_r};
      dtks_pkg::REG_TOP_COUNT:  prdata = {28'd0, top_count_r};
      default:                  prdata = '0;
    endcase
  end

  // Front: numbering and dequantization
  dtks_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .quant_mode (quant_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue
  dtks_queue #(
    .DEPTH (dtks_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: top-K list and reporting
  dtks_back #(
    .MAX_KEPT (MAX_KEPT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .top_count (top_count_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result handshake qualifiers
  assign out_take = out_valid && out_ready;
  assign out_more = out_take && !out_data.final_result;
  assign out_last = out_take && out_data.final_result;

  // A report runs without gaps until its final entry
  `AST_NEXT(a_report_contiguous, out_more, out_valid)

  // Ranks step by one within a report
  `AST_NEXT(a_rank_steps, out_more, out_data.rank_position == $past(out_data.rank_position) + 3'd1)

  // The best entry always opens a report
  `AST_NEXT(a_rank_restart, out_last, !out_valid || out_data.rank_position == 3'd0)

endmodule
